FILE: rtl/serial_packet_to_ppm_generator_unit_defines.svh
`ifndef SERIAL_PACKET_TO_PPM_GENERATOR_UNIT_DEFINES_SVH
`define SERIAL_PACKET_TO_PPM_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, reset masked.
`define SPPPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spppg assertion failed");

// Next-cycle implication, reset masked.
`define SPPPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spppg assertion failed");

`endif

FILE: rtl/spppg_pkg.sv
package spppg_pkg;

    localparam int DEF_NUM_CHANS = 9;
    localparam int DEF_PPM_SLOTS = 8;
    localparam int PIN_OUTPUTS   = 7;

    localparam int TICK_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int LEVEL_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] MARK_START = 8'hFF;
    localparam logic [BYTE_W-1:0] MARK_END   = 8'hEE;

    localparam logic [TICK_W-1:0] PRE_PULSE_RESET = 16'd2949;
    localparam logic [TICK_W-1:0] SYNC_GAP_RESET  = 16'd30966;

    localparam logic [CFG_IDX_W-1:0] REG_PRE_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP  = 2'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic tick;
        logic accept;
    } spppg_op_t;

endpackage

FILE: rtl/spppg_if.sv
interface spppg_step_if import spppg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink (input valid, command, rx_byte, output ready);
endinterface

interface spppg_result_if import spppg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ppm_level;
    logic [LEVEL_W-1:0] channel_levels;
    logic               frame_accepted;
    logic               generator_busy;

    modport source (output valid, ppm_level, channel_levels, frame_accepted, generator_busy,
                    input ready);
    modport sink (input valid, ppm_level, channel_levels, frame_accepted, generator_busy,
                  output ready);
endinterface

interface spppg_cfg_if import spppg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/spppg_deframer.sv
module spppg_deframer import spppg_pkg::*; #(
    parameter int NUM_CHANS = DEF_NUM_CHANS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [TICK_W-1:0] pre_pulse,
    output logic              push,
    output spppg_op_t         push_op,
    input  logic              q_full,
    output logic [TICK_W-1:0] staged_widths [NUM_CHANS]
);

    localparam int PKT_LEN = 2 * NUM_CHANS;
    localparam int IDX_W   = $clog2(PKT_LEN + 1);
    localparam int PIDX_W  = $clog2(PKT_LEN);

    typedef enum logic [1:0] {
        DF_HUNT,
        DF_SECOND,
        DF_DATA,
        DF_VERIFY
    } df_state_t;

    df_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BYTE_W-1:0]  pkt_reg [PKT_LEN];
    logic [TICK_W-1:0]  widths_reg [NUM_CHANS];
    logic               take;
    logic               byte_take;
    logic               good;

    assign in_ready  = !q_full;
    assign take      = in_valid && in_ready;
    assign byte_take = take && !command;
    assign good      = (state_reg == DF_VERIFY) && (rx_byte == MARK_END);

    assign push           = take;
    assign push_op.tick   = command;
    assign push_op.accept = !command && good;

    assign staged_widths = widths_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            DF_HUNT:
            begin
                if (rx_byte == MARK_START)
                    state_next = DF_SECOND;
            end
            DF_SECOND:
            begin
                if (rx_byte == MARK_START)
                begin
                    state_next = DF_DATA;
                    idx_next   = '0;
                end
                else
                    state_next = DF_HUNT;
            end
            DF_DATA:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_next == IDX_W'(PKT_LEN))
                    state_next = DF_VERIFY;
            end
            default:
            begin
                state_next = DF_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DF_HUNT;
            idx_reg   <= '0;
        end
        else if (byte_take)
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take && state_reg == DF_DATA)
            pkt_reg[idx_reg[PIDX_W-1:0]] <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANS; c++)
                widths_reg[c] <= '0;
        end
        else if (byte_take && good)
        begin
            for (int c = 0; c < NUM_CHANS; c++)
                widths_reg[c] <= {pkt_reg[2*c], pkt_reg[2*c+1]} - pre_pulse;
        end
    end

endmodule

FILE: rtl/spppg_queue.sv
module spppg_queue import spppg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  spppg_op_t push_op,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output spppg_op_t head_op
);

    spppg_op_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = mem_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/spppg_generator.sv
module spppg_generator import spppg_pkg::*; #(
    parameter int NUM_CHANS = DEF_NUM_CHANS,
    parameter int PPM_SLOTS = DEF_PPM_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  spppg_op_t          head_op,
    output logic               pop,
    input  logic [TICK_W-1:0]  staged_widths [NUM_CHANS],
    input  logic [TICK_W-1:0]  pre_pulse,
    input  logic [TICK_W-1:0]  sync_gap,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ppm_level,
    output logic [LEVEL_W-1:0] channel_levels,
    output logic               frame_accepted,
    output logic               generator_busy
);

    localparam int SLOT_W = $clog2(PPM_SLOTS + 1);

    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_PULSE,
        GEN_GAP
    } gen_state_t;

    gen_state_t         phase_reg, phase_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               pend_reg, pend_next;
    logic [TICK_W-1:0]  widths_reg [NUM_CHANS];
    logic [TICK_W-1:0]  widths_next [NUM_CHANS];
    logic               out_valid_reg, out_valid_next;
    logic               ppm_reg, acc_reg, busy_reg, acc_next;
    logic [LEVEL_W-1:0] lv_reg, lv_next;
    logic [TICK_W-1:0]  tick_inc;
    logic [TICK_W-1:0]  gap_len;
    logic [TICK_W-1:0]  phase_len;

    assign pop            = head_valid && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign ppm_level      = ppm_reg;
    assign channel_levels = lv_reg;
    assign frame_accepted = acc_reg;
    assign generator_busy = busy_reg;

    assign tick_inc = tick_reg + 1'b1;

    always_comb
    begin
        gap_len = '0;
        for (int c = 0; c < NUM_CHANS; c++)
        begin
            if (c < PPM_SLOTS && slot_reg == SLOT_W'(c))
                gap_len = widths_reg[c];
        end
        if (phase_reg == GEN_PULSE)
            phase_len = pre_pulse;
        else if (slot_reg < SLOT_W'(PPM_SLOTS))
            phase_len = gap_len;
        else
            phase_len = sync_gap;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        slot_next   = slot_reg;
        tick_next   = tick_reg;
        pend_next   = pend_reg;
        widths_next = widths_reg;
        acc_next    = 1'b0;
        if (head_op.tick)
        begin
            if (phase_reg != GEN_IDLE)
            begin
                if (tick_inc != phase_len)
                    tick_next = tick_inc;
                else
                begin
                    tick_next = '0;
                    if (phase_reg == GEN_PULSE)
                        phase_next = GEN_GAP;
                    else if (slot_reg < SLOT_W'(PPM_SLOTS))
                    begin
                        slot_next  = slot_reg + 1'b1;
                        phase_next = GEN_PULSE;
                    end
                    else if (pend_reg)
                    begin
                        pend_next  = 1'b0;
                        phase_next = GEN_PULSE;
                        slot_next  = '0;
                    end
                    else
                    begin
                        phase_next = GEN_IDLE;
                        slot_next  = '0;
                    end
                end
            end
        end
        else if (head_op.accept)
        begin
            acc_next    = 1'b1;
            widths_next = staged_widths;
            if (phase_reg == GEN_IDLE)
            begin
                phase_next = GEN_PULSE;
                slot_next  = '0;
                tick_next  = '0;
            end
            else
                pend_next = 1'b1;
        end

        for (int i = 0; i < LEVEL_W; i++)
        begin
            lv_next[i] = (i + 1 < PIN_OUTPUTS) && (i < PPM_SLOTS) &&
                         (phase_next != GEN_IDLE) && (slot_next == SLOT_W'(i));
        end

        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= GEN_IDLE;
            slot_reg      <= '0;
            tick_reg      <= '0;
            pend_reg      <= 1'b0;
            for (int c = 0; c < NUM_CHANS; c++)
                widths_reg[c] <= '0;
            out_valid_reg <= 1'b0;
            ppm_reg       <= 1'b0;
            lv_reg        <= '0;
            acc_reg       <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg  <= phase_next;
                slot_reg   <= slot_next;
                tick_reg   <= tick_next;
                pend_reg   <= pend_next;
                widths_reg <= widths_next;
                ppm_reg    <= (phase_next == GEN_PULSE);
                lv_reg     <= lv_next;
                acc_reg    <= acc_next;
                busy_reg   <= (phase_next != GEN_IDLE);
            end
        end
    end

endmodule

FILE: rtl/serial_packet_to_ppm_generator_unit.sv
// channel  role   payload
// step     sink   command, rx_byte
// result   source ppm_level, channel_levels, frame_accepted, generator_busy
// cfg      sink   index, data (pre-pulse ticks, sync gap ticks)
//
// One transaction per cycle sustained while the result is taken; a step is
// queued, then registered as a result. Deframer updates on accept, a
// two-entry queue feeds the generator, which owns the result register.
// Config writes are always ready; write only while no transaction is in flight.
// Async active-low reset clears all control state; generator starts idle.
module serial_packet_to_ppm_generator_unit import spppg_pkg::*; #(
    parameter int NUM_CHANS = DEF_NUM_CHANS,
    parameter int PPM_SLOTS = DEF_PPM_SLOTS
) (
    input  logic          clk,
    input  logic          rst_n,
    spppg_step_if.sink    step,
    spppg_result_if.source result,
    spppg_cfg_if.sink     cfg
);

    logic [TICK_W-1:0] pre_pulse_reg;
    logic [TICK_W-1:0] sync_gap_reg;
    logic              push, q_full, pop, head_valid;
    spppg_op_t         push_op, head_op;
    logic [TICK_W-1:0] staged_widths [NUM_CHANS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_pulse_reg <= PRE_PULSE_RESET;
            sync_gap_reg  <= SYNC_GAP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PRE_PULSE: pre_pulse_reg <= cfg.data;
                REG_SYNC_GAP:  sync_gap_reg  <= cfg.data;
                default:       ;
            endcase
        end
    end

    spppg_deframer #(
        .NUM_CHANS(NUM_CHANS)
    ) u_deframer (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (step.valid),
        .in_ready     (step.ready),
        .command      (step.command),
        .rx_byte      (step.rx_byte),
        .pre_pulse    (pre_pulse_reg),
        .push         (push),
        .push_op      (push_op),
        .q_full       (q_full),
        .staged_widths(staged_widths)
    );

    spppg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_op   (head_op)
    );

    spppg_generator #(
        .NUM_CHANS(NUM_CHANS),
        .PPM_SLOTS(PPM_SLOTS)
    ) u_generator (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_op       (head_op),
        .pop           (pop),
        .staged_widths (staged_widths),
        .pre_pulse     (pre_pulse_reg),
        .sync_gap      (sync_gap_reg),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .ppm_level     (result.ppm_level),
        .channel_levels(result.channel_levels),
        .frame_accepted(result.frame_accepted),
        .generator_busy(result.generator_busy)
    );

endmodule

FILE: rtl/spppg_checker.sv
`include "serial_packet_to_ppm_generator_unit_defines.svh"

module spppg_checker import spppg_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               ppm_level,
    input logic [LEVEL_W-1:0] channel_levels,
    input logic               frame_accepted,
    input logic               generator_busy
);

    `SPPPG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(channel_levels))
    `SPPPG_ASSERT_NOW(a_pulse_busy, clk, rst_n, out_valid && ppm_level, generator_busy)
    `SPPPG_ASSERT_NOW(a_one_pin, clk, rst_n, out_valid, $onehot0(channel_levels))
    `SPPPG_ASSERT_NOW(a_accept_busy, clk, rst_n, out_valid && frame_accepted, generator_busy)

endmodule

bind serial_packet_to_ppm_generator_unit spppg_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .ppm_level     (result.ppm_level),
    .channel_levels(result.channel_levels),
    .frame_accepted(result.frame_accepted),
    .generator_busy(result.generator_busy)
);
